// ===== hw/rtl/rtpk_pkg.sv =====
// Package for the H.264 RTP packetizer: beat structs, register indexes,
// the per-item job descriptor and RTP/FU-A constants.
// No dependencies.
package rtpk_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int LIM_W      = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SSRC         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TS_START     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TS_INCREMENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RTP_PT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [31:0]      RST_TS_INCREMENT = 32'd3600;
  localparam logic [6:0]       RST_RTP_PT       = 7'd96;
  localparam logic [LIM_W-1:0] RST_MAX_PAYLOAD  = 11'd1400;
  localparam logic [LIM_W-1:0] MIN_LIMIT        = 11'd2;

  // Protocol constants.
  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0] NRI_MASK         = 8'hE0;
  localparam logic [7:0] TYPE_MASK        = 8'h1F;
  localparam logic [7:0] FU_A_TYPE        = 8'd28;

  // Position of a beat inside the results of one input byte.
  typedef enum logic [3:0] {
    POS_VER     = 4'd0,
    POS_PT      = 4'd1,
    POS_SEQ_HI  = 4'd2,
    POS_SEQ_LO  = 4'd3,
    POS_TS_3    = 4'd4,
    POS_TS_2    = 4'd5,
    POS_TS_1    = 4'd6,
    POS_TS_0    = 4'd7,
    POS_SSRC_3  = 4'd8,
    POS_SSRC_2  = 4'd9,
    POS_SSRC_1  = 4'd10,
    POS_SSRC_0  = 4'd11,
    POS_FU_IND  = 4'd12,
    POS_FU_HDR  = 4'd13,
    POS_DATA    = 4'd14
  } pos_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        nal_start;
    logic [15:0] nal_length;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_first;
    logic       packet_last;
    logic       run_last;
  } out_beat_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [31:0]      ssrc;
    logic [31:0]      ts_increment;
    logic [6:0]       rtp_pt;
    logic [LIM_W-1:0] limit;
  } cfg_t;

  // Everything the serializer needs to emit the results of one input byte.
  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] ts;
    logic        marker;
    logic        s_bit;
    logic        e_bit;
    logic [7:0]  hdr;
    logic [7:0]  data;
    logic        data_last;
    logic        has_hdr;
    logic        has_fu;
    logic        has_data;
  } job_t;

endpackage

// ===== hw/rtl/rtpk_cfg_regs.sv =====
// Configuration register file of the H.264 RTP packetizer.
// Depends on rtpk_pkg.
module rtpk_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  rtpk_pkg::cfg_wr_t cfg_wr,
  output rtpk_pkg::cfg_t   cfg
);

  logic [31:0]                ssrc_r;
  logic [31:0]                ts_inc_r;
  logic [6:0]                 pt_r;
  logic [rtpk_pkg::LIM_W-1:0] max_pl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ssrc_r   <= '0;
      ts_inc_r <= rtpk_pkg::RST_TS_INCREMENT;
      pt_r     <= rtpk_pkg::RST_RTP_PT;
      max_pl_r <= rtpk_pkg::RST_MAX_PAYLOAD;
    end else if (cfg_wr.we) begin
      case (cfg_wr.idx)
        rtpk_pkg::REG_SSRC:         ssrc_r   <= cfg_wr.data;
        rtpk_pkg::REG_TS_INCREMENT: ts_inc_r <= cfg_wr.data;
        rtpk_pkg::REG_RTP_PT:       pt_r     <= cfg_wr.data[6:0];
        rtpk_pkg::REG_MAX_PAYLOAD:  max_pl_r <= cfg_wr.data[rtpk_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A limit below two behaves as two.
  always_comb begin
    cfg.ssrc         = ssrc_r;
    cfg.ts_increment = ts_inc_r;
    cfg.rtp_pt       = pt_r;
    cfg.limit        = (max_pl_r < rtpk_pkg::MIN_LIMIT) ? rtpk_pkg::MIN_LIMIT : max_pl_r;
  end

endmodule

// ===== hw/rtl/rtpk_nal_tracker.sv =====
// NAL tracking state of the packetizer: sequence and timestamp counters,
// byte counts, and the job descriptor built for each accepted byte.
// Depends on rtpk_pkg.
module rtpk_nal_tracker #(
  parameter int LENGTH_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rtpk_pkg::cfg_wr_t  cfg_wr,
  input  rtpk_pkg::cfg_t     cfg,
  input  logic               take,
  input  rtpk_pkg::in_beat_t in_beat,
  output logic               job_load,
  output rtpk_pkg::job_t     job
);

  localparam int PKT_W = rtpk_pkg::LIM_W;

  logic [15:0]            seq_r, seq_nxt;
  logic [31:0]            ts_r, ts_nxt;
  logic [LENGTH_BITS-1:0] nal_r, nal_nxt;
  logic [PKT_W-1:0]       pkt_r, pkt_nxt;
  logic [7:0]             hdr_r, hdr_nxt;
  logic                   frag_r, frag_nxt;

  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] lim_ext;
  logic [PKT_W-1:0]       pkt_cur;
  logic                   last_frag;

  assign len     = LENGTH_BITS'(in_beat.nal_length);
  assign lim_ext = LENGTH_BITS'(cfg.limit);

  always_comb begin
    seq_nxt   = seq_r;
    ts_nxt    = ts_r;
    nal_nxt   = nal_r;
    pkt_nxt   = pkt_r;
    hdr_nxt   = hdr_r;
    frag_nxt  = frag_r;
    pkt_cur   = pkt_r;
    last_frag = 1'b0;
    job_load  = 1'b0;
    job       = '0;
    job.seq   = seq_r + 16'd1;
    job.ts    = ts_r;
    job.hdr   = hdr_r;
    job.data  = in_beat.data;

    if (take) begin
      if (in_beat.nal_start) begin
        if (len == '0) begin
          // Empty NAL: drop it and abandon whatever was open.
          nal_nxt  = '0;
          pkt_nxt  = '0;
          frag_nxt = 1'b0;
        end else begin
          ts_nxt      = ts_r + cfg.ts_increment;
          job.ts      = ts_nxt;
          hdr_nxt     = in_beat.data;
          job.hdr     = in_beat.data;
          nal_nxt     = len - 1'b1;
          seq_nxt     = seq_r + 16'd1;
          job_load    = 1'b1;
          job.has_hdr = 1'b1;
          if (len <= lim_ext) begin
            frag_nxt      = 1'b0;
            job.has_data  = 1'b1;
            job.data_last = (len == LENGTH_BITS'(1));
            pkt_nxt       = PKT_W'(len - 1'b1);
          end else begin
            frag_nxt   = 1'b1;
            job.has_fu = 1'b1;
            job.s_bit  = 1'b1;
            pkt_nxt    = cfg.limit - 1'b1;
          end
        end
      end else if (nal_r != '0) begin
        if (pkt_r == '0 && !frag_r) begin
          nal_nxt = '0;
        end else begin
          if (pkt_r == '0) begin
            // Open the next fragment.
            last_frag   = (nal_r <= lim_ext);
            pkt_cur     = last_frag ? nal_r[PKT_W-1:0] : cfg.limit;
            seq_nxt     = seq_r + 16'd1;
            job.has_hdr = 1'b1;
            job.has_fu  = 1'b1;
            job.marker  = last_frag;
            job.e_bit   = last_frag;
          end
          pkt_nxt       = pkt_cur - 1'b1;
          nal_nxt       = nal_r - 1'b1;
          job_load      = 1'b1;
          job.has_data  = 1'b1;
          job.data_last = (pkt_nxt == '0);
          if (nal_nxt == '0) begin
            frag_nxt = 1'b0;
          end
        end
      end
    end

    if (cfg_wr.we && cfg_wr.idx == rtpk_pkg::REG_SEQ_START) begin
      seq_nxt = cfg_wr.data[15:0];
    end
    if (cfg_wr.we && cfg_wr.idx == rtpk_pkg::REG_TS_START) begin
      ts_nxt = cfg_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      ts_r   <= '0;
      nal_r  <= '0;
      pkt_r  <= '0;
      hdr_r  <= '0;
      frag_r <= 1'b0;
    end else begin
      seq_r  <= seq_nxt;
      ts_r   <= ts_nxt;
      nal_r  <= nal_nxt;
      pkt_r  <= pkt_nxt;
      hdr_r  <= hdr_nxt;
      frag_r <= frag_nxt;
    end
  end

endmodule

// ===== hw/rtl/rtpk_serializer.sv =====
// Job register and byte serializer: walks one job's positions and drives
// the registered result channel.
// Depends on rtpk_pkg.
module rtpk_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  rtpk_pkg::cfg_t      cfg,
  input  logic                take,
  input  logic                job_load,
  input  rtpk_pkg::job_t      job,
  output logic                job_free,
  output logic                out_valid,
  input  logic                out_ready,
  output rtpk_pkg::out_beat_t out_data
);

  rtpk_pkg::job_t      job_r;
  logic                job_valid_r;
  rtpk_pkg::pos_t      pos_r, pos_nxt;
  rtpk_pkg::out_beat_t out_r, beat;
  logic                out_valid_r;
  logic                adv;
  logic                last_beat;

  assign adv       = job_valid_r && (!out_valid_r || out_ready);
  assign last_beat = (pos_r == rtpk_pkg::POS_DATA) ||
                     (pos_r == rtpk_pkg::POS_FU_HDR && !job_r.has_data);
  assign job_free  = !job_valid_r || (adv && last_beat);

  always_comb begin
    case (pos_r)
      rtpk_pkg::POS_SSRC_0: pos_nxt = job_r.has_fu ? rtpk_pkg::POS_FU_IND : rtpk_pkg::POS_DATA;
      rtpk_pkg::POS_FU_HDR: pos_nxt = rtpk_pkg::POS_DATA;
      rtpk_pkg::POS_DATA:   pos_nxt = rtpk_pkg::POS_DATA;
      default:              pos_nxt = rtpk_pkg::pos_t'(pos_r + 4'd1);
    endcase
  end

  always_comb begin
    beat              = '0;
    beat.packet_first = (pos_r == rtpk_pkg::POS_VER);
    beat.packet_last  = (pos_r == rtpk_pkg::POS_DATA) && job_r.data_last;
    beat.run_last     = last_beat;
    case (pos_r)
      rtpk_pkg::POS_VER:    beat.out_byte = rtpk_pkg::RTP_VERSION_BYTE;
      rtpk_pkg::POS_PT:     beat.out_byte = {job_r.marker, cfg.rtp_pt};
      rtpk_pkg::POS_SEQ_HI: beat.out_byte = job_r.seq[15:8];
      rtpk_pkg::POS_SEQ_LO: beat.out_byte = job_r.seq[7:0];
      rtpk_pkg::POS_TS_3:   beat.out_byte = job_r.ts[31:24];
      rtpk_pkg::POS_TS_2:   beat.out_byte = job_r.ts[23:16];
      rtpk_pkg::POS_TS_1:   beat.out_byte = job_r.ts[15:8];
      rtpk_pkg::POS_TS_0:   beat.out_byte = job_r.ts[7:0];
      rtpk_pkg::POS_SSRC_3: beat.out_byte = cfg.ssrc[31:24];
      rtpk_pkg::POS_SSRC_2: beat.out_byte = cfg.ssrc[23:16];
      rtpk_pkg::POS_SSRC_1: beat.out_byte = cfg.ssrc[15:8];
      rtpk_pkg::POS_SSRC_0: beat.out_byte = cfg.ssrc[7:0];
      rtpk_pkg::POS_FU_IND: beat.out_byte = (job_r.hdr & rtpk_pkg::NRI_MASK) | rtpk_pkg::FU_A_TYPE;
      rtpk_pkg::POS_FU_HDR: beat.out_byte = {job_r.s_bit, job_r.e_bit, 1'b0, job_r.hdr[4:0]};
      rtpk_pkg::POS_DATA:   beat.out_byte = job_r.data;
      default:              beat.out_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      pos_r       <= rtpk_pkg::POS_VER;
      out_valid_r <= 1'b0;
    end else begin
      if (take && job_load) begin
        job_valid_r <= 1'b1;
        pos_r       <= job.has_hdr ? rtpk_pkg::POS_VER : rtpk_pkg::POS_DATA;
      end else if (adv && last_beat) begin
        job_valid_r <= 1'b0;
      end else if (adv) begin
        pos_r <= pos_nxt;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && job_load) begin
      job_r <= job;
    end
    if (adv) begin
      out_r <= beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/h264_rtp_packetizer.sv =====
// H.264 RTP packetizer top level. A data byte that stays inside its packet
// gives one result beat; a byte that opens a packet gives 13 to 15 beats,
// which the serializer emits one byte per cycle unless the output stalls.
// An input byte is accepted in the cycle its predecessor's last beat moves to
// the output register; its job is registered first, then each of its beats.
// Synchronous active-low reset clears the counters, control state and config.
module h264_rtp_packetizer #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rtpk_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rtpk_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [rtpk_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [rtpk_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // The write port is gathered into one struct for the register file and
  // the tracker, which loads the running sequence and timestamp counters.
  rtpk_pkg::cfg_wr_t cfg_wr;
  rtpk_pkg::cfg_t    cfg;
  rtpk_pkg::job_t    job;
  logic              job_load;
  logic              job_free;
  logic              take;

  assign cfg_wr.we   = cfg_we;
  assign cfg_wr.idx  = cfg_idx;
  assign cfg_wr.data = cfg_wdata;

  // A new byte is taken whenever the job register is empty or its last beat
  // leaves this cycle; plain payload bytes stream at one per cycle unless stalled.
  assign in_ready = job_free;
  assign take     = in_valid && in_ready;

  rtpk_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  // The tracker decides, for each accepted byte, which header, FU-A bytes
  // and data beat it causes, and advances the NAL and packet counts.
  rtpk_nal_tracker #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_trk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .cfg      (cfg),
    .take     (take),
    .in_beat  (in_data),
    .job_load (job_load),
    .job      (job)
  );

  // The serializer holds the job and drives the registered result beats.
  rtpk_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .take      (take),
    .job_load  (job_load),
    .job       (job),
    .job_free  (job_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/rtpk_checker.sv =====
// Port-level checks for the H.264 RTP packetizer, bound to the top level.
// Depends on rtpk_pkg and h264_rtp_packetizer.
module rtpk_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input rtpk_pkg::out_beat_t out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Every packet opens with the RTP version byte.
  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.packet_first |-> out_data.out_byte == rtpk_pkg::RTP_VERSION_BYTE)
    else $error("packet does not start with version byte");

  // The last byte of a packet is always the last beat of its input byte.
  a_last_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.packet_last |-> out_data.run_last && !out_data.packet_first)
    else $error("packet end not on run end");

  // Reset leaves the result channel empty.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind h264_rtp_packetizer rtpk_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/rtp_stream_checker.sv =====
// Scoreboard for the H.264 RTP packetizer: mirrors the register writes, predicts the
// packet beats of every accepted NAL byte and compares them with the output channel.
// Depends on rtpk_pkg for the beat structs, register indexes and protocol constants.
module rtp_stream_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  rtpk_pkg::in_beat_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  rtpk_pkg::out_beat_t             out_data,
  input  logic                            cfg_we,
  input  logic [rtpk_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rtpk_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatch_count,
  output int                              beats_pending
);

  // Register mirror.
  logic [31:0]                ssrc_r;
  logic [31:0]                ts_step_r;
  logic [6:0]                 pt_r;
  logic [rtpk_pkg::LIM_W-1:0] max_pl_r;

  // Packetizer state.
  logic [15:0] seq_cnt;
  logic [31:0] ts_cnt;
  int unsigned nal_left;
  int unsigned pkt_left;
  logic [7:0]  nal_hdr;
  logic        frag_open;

  rtpk_pkg::out_beat_t packet_beats[$];
  rtpk_pkg::out_beat_t byte_run[$];
  int                  results_seen;

  initial begin
    mismatch_count = 0;
    beats_pending  = 0;
    results_seen   = 0;
  end

  function automatic int unsigned payload_limit();
    return (max_pl_r < rtpk_pkg::MIN_LIMIT) ? int'(rtpk_pkg::MIN_LIMIT) : int'(max_pl_r);
  endfunction

  function automatic void add_beat(input logic [7:0] b, input logic first, input logic last);
    rtpk_pkg::out_beat_t beat;
    beat.out_byte     = b;
    beat.packet_first = first;
    beat.packet_last  = last;
    beat.run_last     = 1'b0;
    byte_run.push_back(beat);
  endfunction

  function automatic void add_rtp_header(input logic marker);
    seq_cnt = seq_cnt + 16'd1;
    add_beat(rtpk_pkg::RTP_VERSION_BYTE, 1'b1, 1'b0);
    add_beat({marker, pt_r}, 1'b0, 1'b0);
    add_beat(seq_cnt[15:8], 1'b0, 1'b0);
    add_beat(seq_cnt[7:0], 1'b0, 1'b0);
    add_beat(ts_cnt[31:24], 1'b0, 1'b0);
    add_beat(ts_cnt[23:16], 1'b0, 1'b0);
    add_beat(ts_cnt[15:8], 1'b0, 1'b0);
    add_beat(ts_cnt[7:0], 1'b0, 1'b0);
    add_beat(ssrc_r[31:24], 1'b0, 1'b0);
    add_beat(ssrc_r[23:16], 1'b0, 1'b0);
    add_beat(ssrc_r[15:8], 1'b0, 1'b0);
    add_beat(ssrc_r[7:0], 1'b0, 1'b0);
  endfunction

  function automatic void add_fu_bytes(input logic s_bit, input logic e_bit);
    add_beat((nal_hdr & rtpk_pkg::NRI_MASK) | rtpk_pkg::FU_A_TYPE, 1'b0, 1'b0);
    add_beat({s_bit, e_bit, 6'b0} | (nal_hdr & rtpk_pkg::TYPE_MASK), 1'b0, 1'b0);
  endfunction

  // Works out the beats that one accepted NAL byte causes.
  function automatic void packetize_byte(input rtpk_pkg::in_beat_t b);
    int unsigned lim;
    int unsigned len;
    logic        last;
    lim = payload_limit();
    len = b.nal_length;
    byte_run.delete();
    if (b.nal_start) begin
      if (len == 0) begin
        nal_left  = 0;
        pkt_left  = 0;
        frag_open = 1'b0;
        return;
      end
      ts_cnt   = ts_cnt + ts_step_r;
      nal_hdr  = b.data;
      nal_left = len - 1;
      add_rtp_header(1'b0);
      if (len <= lim) begin
        frag_open = 1'b0;
        add_beat(b.data, 1'b0, len == 1);
        pkt_left = len - 1;
      end else begin
        frag_open = 1'b1;
        add_fu_bytes(1'b1, 1'b0);
        pkt_left = lim - 1;
      end
    end else begin
      if (nal_left == 0) return;
      if (pkt_left == 0) begin
        if (!frag_open) begin
          nal_left = 0;
          return;
        end
        last     = (nal_left <= lim);
        pkt_left = last ? nal_left : lim;
        add_rtp_header(last);
        add_fu_bytes(1'b0, last);
      end
      pkt_left--;
      nal_left--;
      add_beat(b.data, 1'b0, pkt_left == 0);
      if (nal_left == 0) frag_open = 1'b0;
    end
    if (byte_run.size() > 0) begin
      byte_run[byte_run.size()-1].run_last = 1'b1;
      foreach (byte_run[i]) packet_beats.push_back(byte_run[i]);
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] beat %0d: %s got %02h, expected %02h",
             $time, results_seen, field, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input rtpk_pkg::out_beat_t got);
    rtpk_pkg::out_beat_t want;
    if (packet_beats.size() == 0) begin
      report_mismatch("beat with nothing expected, out_byte", got.out_byte, 8'h00);
    end else begin
      want = packet_beats.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch("out_byte", got.out_byte, want.out_byte);
      if (got.packet_first !== want.packet_first)
        report_mismatch("packet_first", {7'b0, got.packet_first}, {7'b0, want.packet_first});
      if (got.packet_last !== want.packet_last)
        report_mismatch("packet_last", {7'b0, got.packet_last}, {7'b0, want.packet_last});
      if (got.run_last !== want.run_last)
        report_mismatch("run_last", {7'b0, got.run_last}, {7'b0, want.run_last});
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ssrc_r    = '0;
      ts_step_r = rtpk_pkg::RST_TS_INCREMENT;
      pt_r      = rtpk_pkg::RST_RTP_PT;
      max_pl_r  = rtpk_pkg::RST_MAX_PAYLOAD;
      seq_cnt   = '0;
      ts_cnt    = '0;
      nal_left  = 0;
      pkt_left  = 0;
      nal_hdr   = '0;
      frag_open = 1'b0;
      packet_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          rtpk_pkg::REG_SSRC:         ssrc_r    = cfg_wdata;
          rtpk_pkg::REG_SEQ_START:    seq_cnt   = cfg_wdata[15:0];
          rtpk_pkg::REG_TS_START:     ts_cnt    = cfg_wdata;
          rtpk_pkg::REG_TS_INCREMENT: ts_step_r = cfg_wdata;
          rtpk_pkg::REG_RTP_PT:       pt_r      = cfg_wdata[6:0];
          rtpk_pkg::REG_MAX_PAYLOAD:  max_pl_r  = cfg_wdata[rtpk_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) packetize_byte(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
    beats_pending <= packet_beats.size();
  end

endmodule

// ===== tb/sv/h264_rtp_packetizer_tb.sv =====
// Top-level testbench for the H.264 RTP packetizer: drives NAL bytes, register writes
// and output back-pressure, and gives the verdict from the scoreboard's mismatch count.
// Depends on rtpk_pkg, h264_rtp_packetizer and rtp_stream_checker.
module h264_rtp_packetizer_tb;

  // The receiver's long hold-off; the block must fill up and stall its input meanwhile.
  localparam int HOLD_CYCLES    = 400;
  // Cycles without any beat, write or reset before the run is declared hung. The longest
  // legal quiet stretch is the hold-off above, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 5000;
  // Settling time after the last expected beat. Stray and zero-length bytes cause no
  // beats, so the block may still be chewing on one when the scoreboard runs empty.
  localparam int DRAIN_CYCLES   = 20;
  localparam int BATCH_ITEMS    = 24;
  localparam int NUM_BATCHES    = 6;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  rtpk_pkg::in_beat_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  rtpk_pkg::out_beat_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [rtpk_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [rtpk_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int          mismatch_count;
  int          beats_pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int unsigned eff_limit      = rtpk_pkg::RST_MAX_PAYLOAD;
  int          quiet_cycles   = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  h264_rtp_packetizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  rtp_stream_checker stream_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .beats_pending  (beats_pending)
  );

  // Receiver. Every falling edge it decides whether to take the next beat. When a
  // hold-off is requested it keeps ready low for HOLD_CYCLES, counted here, while the
  // sender keeps offering bytes.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any handshake, register write or reset counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one byte and returns at the rising edge where it is accepted. Valid is left
  // high so that back-to-back bytes need no gap; idle cycles, each drawn with the
  // sender's idle chance, go in front of the byte while the previous byte is gone.
  task automatic send_beat(input logic [7:0] b, input logic start, input logic [15:0] len);
    rtpk_pkg::in_beat_t beat;
    beat.data       = b;
    beat.nal_start  = start;
    beat.nal_length = len;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sends the first `count` bytes of a NAL whose header announces `len` bytes. When
  // count is short of len the NAL is left open, to be cut off by the next start.
  // The length field of continuation bytes is don't-care, so it carries noise.
  task automatic send_nal(input logic [7:0] hdr, input logic [15:0] len,
                          input int unsigned count);
    send_beat(hdr, 1'b1, len);
    for (int unsigned i = 1; i < count; i++)
      send_beat(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)));
  endtask

  // Drops valid and waits until every predicted beat has come out, then lets the block
  // finish anything that produces no beats. Registers are only written after this.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (beats_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rtpk_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // The payload limit is also tracked here so that NAL lengths can be aimed at the
  // single-packet / FU-A boundary. Values below two behave as two.
  task automatic write_limit(input logic [rtpk_pkg::LIM_W-1:0] value);
    write_reg(rtpk_pkg::REG_MAX_PAYLOAD, 32'(value));
    eff_limit = (value < rtpk_pkg::MIN_LIMIT) ? int'(rtpk_pkg::MIN_LIMIT) : int'(value);
  endtask

  // Register settings per batch: the first two are low and high corner settings, the
  // rest are random with limits that range from the clamped minimum to the field's top.
  task automatic configure_batch(input int unsigned batch);
    logic [31:0]                ssrc_v;
    logic [31:0]                ts_v;
    logic [31:0]                inc_v;
    logic [15:0]                seq_v;
    logic [6:0]                 pt_v;
    logic [rtpk_pkg::LIM_W-1:0] lim_v;
    case (batch)
      0: begin
        ssrc_v = '0; seq_v = '0; ts_v = '0; inc_v = '0; pt_v = '0; lim_v = 11'd2;
      end
      1: begin
        ssrc_v = '1; seq_v = 16'hFFF8; ts_v = 32'hFFFF_FF00; inc_v = '1; pt_v = '1;
        lim_v  = 11'd1500;
      end
      default: begin
        ssrc_v = $urandom();
        seq_v  = 16'($urandom_range(65535));
        ts_v   = $urandom();
        inc_v  = ($urandom_range(1) != 0) ? $urandom() : 32'($urandom_range(1, 9000));
        pt_v   = 7'($urandom_range(127));
        case (batch)
          2:       lim_v = 11'd1;
          3:       lim_v = 11'd2047;
          4:       lim_v = 11'($urandom_range(3, 12));
          default: lim_v = 11'($urandom_range(13, 30));
        endcase
      end
    endcase
    write_reg(rtpk_pkg::REG_SSRC, ssrc_v);
    write_reg(rtpk_pkg::REG_TS_INCREMENT, inc_v);
    write_reg(rtpk_pkg::REG_RTP_PT, 32'(pt_v));
    write_limit(lim_v);
    // Later batches sometimes let the counters run on from the previous batch.
    if (batch < 2 || $urandom_range(1) != 0) begin
      write_reg(rtpk_pkg::REG_SEQ_START, 32'(seq_v));
      write_reg(rtpk_pkg::REG_TS_START, ts_v);
    end
  endtask

  // Mostly whole NALs with random content, sized around the fragmentation boundary,
  // plus cut-off NALs, zero-length starts and stray bytes. Every byte sent counts
  // toward the batch, and the last NAL is trimmed so the batch ends on its count.
  task automatic run_batch(input int unsigned n_items);
    int unsigned done;
    int unsigned room;
    int unsigned kind;
    int unsigned span;
    int unsigned len;
    int unsigned count;
    done = 0;
    while (done < n_items) begin
      room = n_items - done;
      kind = $urandom_range(99);
      span = (eff_limit <= 15) ? eff_limit * 3 + 2 : 48;
      if (kind < 78) begin
        len = $urandom_range(1, span);
        if (eff_limit <= 15 && kind < 15) len = eff_limit;
        else if (eff_limit <= 15 && kind < 30) len = eff_limit + 1;
        if (len > room) len = room;
        send_nal(8'($urandom_range(255)), 16'(len), len);
        done += len;
      end else if (kind < 88) begin
        len   = $urandom_range(1, 65535);
        count = $urandom_range(1, 6);
        if (count > len) count = len;
        if (count > room) count = room;
        send_nal(8'($urandom_range(255)), 16'(len), count);
        done += count;
      end else if (kind < 94) begin
        send_beat(8'($urandom_range(255)), 1'b1, 16'h0000);
        done++;
      end else begin
        send_beat(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)));
        done++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, first with the reset register values: a one-byte NAL (its only
    // data byte closes the packet) and a short single-packet NAL.
    send_nal(8'h00, 16'd1, 1);
    send_nal(8'hFF, 16'd3, 3);
    settle();

    // All registers at their top values, and a limit of zero, which acts as two.
    // The sequence number and the timestamp both wrap on the next NAL.
    write_reg(rtpk_pkg::REG_SSRC, 32'hFFFF_FFFF);
    write_reg(rtpk_pkg::REG_SEQ_START, 32'h0000_FFFF);
    write_reg(rtpk_pkg::REG_TS_START, 32'hFFFF_FFFF);
    write_reg(rtpk_pkg::REG_TS_INCREMENT, 32'hFFFF_FFFF);
    write_reg(rtpk_pkg::REG_RTP_PT, 32'h0000_007F);
    write_limit(11'd0);

    // FU-A with the smallest fragments.
    send_nal(8'h65, 16'd5, 5);
    // A continuation byte with no NAL open is ignored.
    send_beat(8'hA5, 1'b0, 16'hFFFF);
    // A start with zero length is dropped.
    send_beat(8'h5A, 1'b1, 16'h0000);
    // A maximum-length NAL cut off by the next start, which fits one packet exactly.
    send_nal(8'h7C, 16'hFFFF, 2);
    send_nal(8'h41, 16'd2, 2);
    // An open FU-A NAL abandoned by a zero-length start; the byte after it is stray.
    send_nal(8'hE1, 16'd6, 3);
    send_beat(8'h00, 1'b1, 16'h0000);
    send_beat(8'hFF, 1'b0, 16'h0000);

    // A limit change in the middle of an FU-A NAL applies from the next fragment.
    send_nal(8'h9F, 16'd9, 3);
    settle();
    write_limit(11'd4);
    for (int i = 0; i < 6; i++)
      send_beat(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)));
    settle();

    // Random part in three idling regimes: sender idles rarely and receiver often,
    // then the other way round, then neither. The last regime opens with the long
    // receiver hold-off so that the block backs up into its input.
    for (int unsigned batch = 0; batch < NUM_BATCHES; batch++) begin
      case (batch / 2)
        0:       begin send_idle_pct = 12; recv_stall_pct = 61; end
        1:       begin send_idle_pct = 61; recv_stall_pct = 12; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      configure_batch(batch);
      if (batch == 4) hold_request = 1'b1;
      run_batch(BATCH_ITEMS);
      settle();
    end

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
